@@ hdl/dnle_pkg.sv @@
package dnle_pkg;

  localparam logic [7:0] DOT_CHAR  = 8'h2E;
  localparam logic [7:0] ROOT_BYTE = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_DATA,
    ST_ROOT
  } dnle_state_t;

  // one output beat on its way through the read stage
  typedef struct packed {
    logic       is_data;  // value comes from the label RAM
    logic [7:0] value;    // length or root byte when not data
    logic       ovf;
    logic       last;
  } dnle_beat_t;

endpackage

@@ hdl/dnle_ram.sv @@
module dnle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 62,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/dns_name_label_encoder_top.sv @@
// A character that causes output moves the sequencer to ST_LEN; its beats then pass
//   through the read stage and the output register. Ordinary characters are taken back
//   to back while idle; a flushing character holds off input until its length byte, label
//   bytes and any root byte have issued, one beat per cycle paced by the label RAM read
//   port; output stalls hold the sequencer in place. Reset (rst, synchronous, active high)
//   clears the sequencer, label count, overflow flag and pipeline valids, not the label RAM.
module dns_name_label_encoder_top
  import dnle_pkg::*;
#(
  parameter int MAX_LABEL = 62
) (
  input  logic       clk,
  input  logic       rst,
  // character input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] name_char,
  input  logic       end_of_name,
  // wire-format output
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] wire_byte,
  output logic       last_of_run,
  output logic       label_overflow
);

  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int CW = $clog2(MAX_LABEL + 1);

  // Sequencer state
  dnle_state_t state, state_next;
  logic [CW-1:0] count, count_next;   // characters held in the label RAM
  logic          ovf, ovf_next;       // a character was dropped from this label
  logic          end_pend, end_pend_next; // root byte owed after the flush
  logic [AW-1:0] idx, idx_next;       // next RAM entry to drain

  // Read stage (beat waiting on RAM data) and output register
  logic       s1_valid;
  dnle_beat_t s1;
  logic       s1_take;
  logic       out_advance;

  logic       issue;
  dnle_beat_t issue_beat;
  logic       rd_en;
  logic [7:0] rd_data;

  logic       in_acc;
  logic       is_dot;
  logic       full;
  logic       ram_we;
  logic       idx_at_end;

  // input only taken while collecting a label
  assign in_ready    = (state == ST_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign is_dot      = (name_char == DOT_CHAR);
  assign full        = (count == CW'(MAX_LABEL));
  assign ram_we      = in_acc && !is_dot && !full;
  assign out_advance = !out_valid || out_ready;
  assign s1_take     = !s1_valid || out_advance;
  assign idx_at_end  = (CW'(idx) == count - CW'(1));

  dnle_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LABEL)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (name_char),
    .re    (rd_en),
    .raddr (idx),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      ovf      <= 1'b0;
      end_pend <= 1'b0;
      idx      <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      ovf      <= ovf_next;
      end_pend <= end_pend_next;
      idx      <= idx_next;
    end
  end

  // Next state and beat issue
  always_comb begin
    state_next    = state;
    count_next    = count;
    ovf_next      = ovf;
    end_pend_next = end_pend;
    idx_next      = idx;
    issue         = 1'b0;
    rd_en         = 1'b0;
    issue_beat    = '0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_dot) begin
            end_pend_next = end_of_name;
            state_next    = ST_LEN;
          end else begin
            if (full) begin
              ovf_next = 1'b1;
            end else begin
              count_next = count + CW'(1);
            end
            if (end_of_name) begin
              end_pend_next = 1'b1;
              state_next    = ST_LEN;
            end
          end
        end
      end
      ST_LEN: begin
        if (s1_take) begin
          issue            = 1'b1;
          issue_beat.value = 8'(count);
          issue_beat.ovf   = ovf;
          issue_beat.last  = (count == '0) && !end_pend;
          idx_next         = '0;
          if (count == '0) begin
            ovf_next   = 1'b0;
            state_next = end_pend ? ST_ROOT : ST_IDLE;
          end else begin
            state_next = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (s1_take) begin
          issue              = 1'b1;
          rd_en              = 1'b1;
          issue_beat.is_data = 1'b1;
          issue_beat.ovf     = ovf;
          issue_beat.last    = idx_at_end && !end_pend;
          idx_next           = idx + AW'(1);
          if (idx_at_end) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = end_pend ? ST_ROOT : ST_IDLE;
          end
        end
      end
      ST_ROOT: begin
        if (s1_take) begin
          issue            = 1'b1;
          issue_beat.value = ROOT_BYTE;
          issue_beat.last  = 1'b1;
          end_pend_next    = 1'b0;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Read stage: RAM data for a data beat lands while the beat sits here.
  // The RAM read only fires on issue, so rd_data holds through a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1 <= issue_beat;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && s1_valid) begin
      wire_byte      <= s1.is_data ? rd_data : s1.value;
      last_of_run    <= s1.last;
      label_overflow <= s1.ovf;
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_LABEL))
    else $error("label count beyond limit");

  a_ovf_only_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (count == CW'(MAX_LABEL)))
    else $error("overflow flag set on a label that is not full");

  a_dot_flushes: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_dot) |=> (state == ST_LEN))
    else $error("dot did not start a flush");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state_next == ST_IDLE) |=> (count == '0 && !ovf && !end_pend))
    else $error("label state not cleared after flush");

  a_root_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT && s1_take) |=> (s1_valid && s1.last && !s1.ovf && !s1.is_data))
    else $error("root beat malformed");

endmodule

@@ dv/tb_dns_name_label_encoder_top.sv @@
module tb_dns_name_label_encoder_top;
  import dnle_pkg::*;

  localparam int LABEL_LIMIT = 62;
  // Slowest legal run: ~300 chars, a flush of up to 64 beats, a receiver with random
  // stall runs, plus the long hold. Several times over.
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_CHARS = 80;

  // one expected beat on the wire side
  typedef struct {
    logic [7:0] wire_byte;
    logic       last;
    logic       ovf;
  } wire_beat_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] name_char;
  logic       end_of_name;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] wire_byte;
  logic       last_of_run;
  logic       label_overflow;

  dns_name_label_encoder_top #(
    .MAX_LABEL(LABEL_LIMIT)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .name_char     (name_char),
    .end_of_name   (end_of_name),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .wire_byte     (wire_byte),
    .last_of_run   (last_of_run),
    .label_overflow(label_overflow)
  );

  // ---------------------------------------------------------------------------
  // Encoder shadow state: the label being collected, and the wire beats that
  // the design still owes us, oldest first.
  // ---------------------------------------------------------------------------
  logic [7:0] label_buf [LABEL_LIMIT];
  int         label_len;
  bit         label_dropped;
  wire_beat_t pending_wire [$];

  // run bookkeeping
  int errors;
  int chars_sent;
  int names_ended;
  int beats_checked;
  int truncated_labels;
  int cycle_count;

  // sender burst control
  bit tx_gaps;
  int burst_left;

  // receiver stall control
  bit rx_stalls;
  bit rx_on;
  int rx_phase_left;
  int hold_req;
  int hold_left;

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Wire-format predictor
  // ---------------------------------------------------------------------------
  function automatic void push_beat(logic [7:0] b, logic ovf);
    wire_beat_t w;
    w.wire_byte = b;
    w.last      = 1'b0;
    w.ovf       = ovf;
    pending_wire.push_back(w);
  endfunction

  // Length byte, then the buffered bytes; all carry the truncation flag.
  function automatic int flush_label();
    int n;
    n = 1 + label_len;
    push_beat(label_len[7:0], label_dropped);
    if (label_dropped) truncated_labels++;
    for (int i = 0; i < label_len; i++) push_beat(label_buf[i], label_dropped);
    label_len     = 0;
    label_dropped = 1'b0;
    return n;
  endfunction

  function automatic void encode_char(logic [7:0] c, logic eon);
    int n_beats;
    n_beats = 0;
    if (c == DOT_CHAR) begin
      n_beats = flush_label();
    end else begin
      // characters past the cap are dropped, and the label gets flagged
      if (label_len < LABEL_LIMIT) begin
        label_buf[label_len] = c;
        label_len++;
      end else begin
        label_dropped = 1'b1;
      end
      if (eon) n_beats = flush_label();
    end
    // the end flag closes the name after any flush: one root byte
    if (eon) begin
      push_beat(ROOT_BYTE, 1'b0);
      n_beats++;
      names_ended++;
    end
    if (n_beats > 0) pending_wire[pending_wire.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side: one beat per call. Valid is only dropped for a gap, so a
  // back-to-back beat never sees valid lowered and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic eon);
    if (tx_gaps) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid    <= 1'b1;
    name_char   <= c;
    end_of_name <= eon;
    do @(posedge clk); while (!in_ready);
    encode_char(c, eon);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input bit end_flag);
    for (int i = 0; i < s.len(); i++) send_char(s[i], end_flag && (i == s.len() - 1));
  endtask

  task automatic send_label_run(input int len);
    for (int i = 0; i < len; i++) send_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Stop offering, let every owed beat drain, then allow for the pipeline.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_wire.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: always ready, or alternating ready/stall runs of random
  // length. A long hold requested by a test is counted down here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!rx_stalls) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_phase_left == 0) begin
        rx_on         = !rx_on;
        rx_phase_left = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 4);
      end
      rx_phase_left--;
      out_ready <= rx_on;
    end
  end

  // ---------------------------------------------------------------------------
  // Output checker: every accepted beat against the oldest owed beat.
  // ---------------------------------------------------------------------------
  wire_beat_t want_beat;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_wire.size() == 0) begin
        $error("unexpected beat: wire_byte %02h last_of_run %0b", wire_byte, last_of_run);
        errors++;
      end else begin
        want_beat = pending_wire.pop_front();
        beats_checked++;
        if (wire_byte !== want_beat.wire_byte) begin
          $error("wire_byte: expected %02h, got %02h", want_beat.wire_byte, wire_byte);
          errors++;
        end
        if (last_of_run !== want_beat.last) begin
          $error("last_of_run: expected %0b, got %0b", want_beat.last, last_of_run);
          errors++;
        end
        if (label_overflow !== want_beat.ovf) begin
          $error("label_overflow: expected %0b, got %0b", want_beat.ovf, label_overflow);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-picked names: each flush path and the byte extremes.
  task automatic test_directed();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_text("a.bc", 1'b1);    // dot flush, then end on an ordinary char
    send_text(".", 1'b1);       // lone root: 0, 0
    send_text(".x", 1'b1);      // leading dot gives an empty label
    send_text("p..q.", 1'b1);   // empty label mid-name, end on a dot
    send_char(8'h00, 1'b0);     // byte extremes inside one label
    send_char(8'hFF, 1'b0);
    send_char(8'h2D, 1'b0);
    send_char(8'h2F, 1'b0);
    send_char(8'h01, 1'b0);
    send_char(8'hFE, 1'b0);
    send_char(8'h80, 1'b1);
    send_text("z", 1'b1);       // one-char name
    wait_drain();
  endtask

  // Labels at and one over the cap.
  task automatic test_label_limit();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_label_run(LABEL_LIMIT);
    send_char(DOT_CHAR, 1'b0);
    send_label_run(LABEL_LIMIT);
    send_char(8'h41, 1'b1);     // end falls on the dropped char
    wait_drain();
  endtask

  task automatic send_random_name();
    int n_labels;
    int len;
    bit fq;
    bit is_end;
    n_labels = $urandom_range(1, 4);
    fq       = ($urandom_range(0, 3) == 0);
    for (int l = 0; l < n_labels; l++) begin
      // mostly short labels, now and then one near or past the cap
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(55, 68) : $urandom_range(0, 9);
      if (len == 0 && l == n_labels - 1 && !fq) len = 1;
      for (int i = 0; i < len; i++) begin
        is_end = !fq && (l == n_labels - 1) && (i == len - 1);
        send_char(8'($urandom_range(0, 255)), is_end);
      end
      if (l < n_labels - 1 || fq) send_char(DOT_CHAR, fq && (l == n_labels - 1));
    end
  endtask

  // Mostly well-formed names with random bytes; some raw noise beats with
  // stray dots and end flags. Sender and receiver pacing change over time.
  task automatic test_random_names();
    int stop_at;
    int n;
    stop_at = chars_sent + RANDOM_CHARS;
    while (chars_sent < stop_at) begin
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
          send_char(($urandom_range(0, 3) == 0) ? DOT_CHAR : 8'($urandom_range(0, 255)),
                    ($urandom_range(0, 3) == 0));
        end
      end else begin
        send_random_name();
      end
    end
    // close whatever noise left open
    send_char(8'h61, 1'b1);
    wait_drain();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // back to back, so the flush path backs up into the input.
  task automatic test_backpressure();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    hold_req  = 400;
    send_label_run(10);
    send_char(DOT_CHAR, 1'b0);
    send_label_run(10);
    send_char(DOT_CHAR, 1'b1);
    rx_stalls = 1'b1;
    send_text("ab.cd", 1'b1);
    wait_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    name_char        = 8'h00;
    end_of_name      = 1'b0;
    out_ready        = 1'b0;
    label_len        = 0;
    label_dropped    = 1'b0;
    errors           = 0;
    chars_sent       = 0;
    names_ended      = 0;
    beats_checked    = 0;
    truncated_labels = 0;
    cycle_count      = 0;
    tx_gaps          = 1'b0;
    burst_left       = 0;
    rx_stalls        = 1'b0;
    rx_on            = 1'b0;
    rx_phase_left    = 0;
    hold_req         = 0;
    hold_left        = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_label_limit();
    test_random_names();
    test_backpressure();

    $display("Encoded %0d chars into %0d names; %0d wire beats checked.",
             chars_sent, names_ended, beats_checked);
    $display("Labels truncated at the cap: %0d; errors: %0d.", truncated_labels, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/dnle_pkg.sv
hdl/dnle_ram.sv
hdl/dns_name_label_encoder_top.sv
dv/tb_dns_name_label_encoder_top.sv
